// ----- sv/hcb_pkg.sv -----
// Shared constants, codes, state and payload types for the Huffman code builder.
package hcb_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int COUNT_W       = 24;
  localparam int MAX_CODE_LEN  = 64;
  localparam int SYM_W         = 8;
  localparam int OP_W          = 2;
  localparam int DIST_W        = 9;
  localparam int NODE_W        = 9;
  localparam int NODE_DEPTH    = 512;
  localparam int WGT_W         = 40;
  localparam int DEPTH_W       = 9;
  localparam int LEN_W         = 7;
  localparam int CODE_W        = 64;
  localparam int BITS_W        = 32;
  localparam int BYTES_W       = 30;
  localparam int PROD_W        = 33;
  localparam int SUM_W         = 41;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_BUILD = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    KIND_TOTALS = 1'b0,
    KIND_ENTRY  = 1'b1
  } kind_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CNT, ST_CNT_MAP, ST_CNT_INC,
    ST_B0, ST_IN_RD, ST_IN_WR,
    ST_HP0, ST_HP_RD, ST_HP_RW, ST_HP_GO, ST_HP_NEXT,
    ST_SD_L, ST_SD_LW, ST_SD_LC, ST_SD_RW, ST_SD_RC, ST_SD_END,
    ST_MG, ST_POP0, ST_POP1, ST_POP2, ST_POP3, ST_POP_DONE, ST_MG_W,
    ST_SU_CHK, ST_SU_RW, ST_SU_CMP, ST_SU_END,
    ST_WK0, ST_WK_CHK, ST_WK_A, ST_WK_R,
    ST_SM_RD, ST_SM_MUL, ST_SM_ADD, ST_FIN,
    ST_RPT, ST_RD0, ST_RD1, ST_EMIT
  } state_e;

  typedef struct packed {
    logic                 kind;
    logic [COUNT_W-1:0]   char_count;
    logic [DIST_W-1:0]    distinct_count;
    logic [BITS_W-1:0]    coded_bits;
    logic [BYTES_W-1:0]   coded_bytes;
    logic [SYM_W-1:0]     entry_symbol;
    logic [COUNT_W-1:0]   entry_freq;
    logic [LEN_W-1:0]     entry_length;
    logic [CODE_W-1:0]    entry_code;
    logic                 entry_valid;
  } res_t;

endpackage

// ----- sv/hcb_req_if.sv -----
// Request channel: op, symbol and slot with valid/ready.
interface hcb_req_if;
  logic                        valid;
  logic                        ready;
  logic [hcb_pkg::OP_W-1:0]    op;
  logic [hcb_pkg::SYM_W-1:0]   symbol;
  logic [hcb_pkg::SYM_W-1:0]   slot;

  modport source (output valid, op, symbol, slot, input ready);
  modport sink   (input valid, op, symbol, slot, output ready);
endinterface

// ----- sv/hcb_res_if.sv -----
// Result channel: totals report or code table entry with valid/ready.
interface hcb_res_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [hcb_pkg::COUNT_W-1:0]    char_count;
  logic [hcb_pkg::DIST_W-1:0]     distinct_count;
  logic [hcb_pkg::BITS_W-1:0]     coded_bits;
  logic [hcb_pkg::BYTES_W-1:0]    coded_bytes;
  logic [hcb_pkg::SYM_W-1:0]      entry_symbol;
  logic [hcb_pkg::COUNT_W-1:0]    entry_freq;
  logic [hcb_pkg::LEN_W-1:0]      entry_length;
  logic [hcb_pkg::CODE_W-1:0]     entry_code;
  logic                           entry_valid;

  modport source (output valid, kind, char_count, distinct_count, coded_bits, coded_bytes,
                  entry_symbol, entry_freq, entry_length, entry_code, entry_valid,
                  input ready);
  modport sink   (input valid, kind, char_count, distinct_count, coded_bits, coded_bytes,
                  entry_symbol, entry_freq, entry_length, entry_code, entry_valid,
                  output ready);
endinterface

// ----- sv/huffman_code_builder.sv -----
// Huffman code builder top level: byte counting, heap-based tree build, code table reads.
//
//  channel | dir | handshake      | carries
//  req_i   | in  | valid/ready    | op, symbol, slot
//  res_o   | out | valid/ready    | totals report (op 1) or table entry (op 2)
//
// Steps: a count request for a new byte writes its new slot directly; a byte seen before
// needs a slot map read, a count read and a count write.
// A build loads the counts, builds the heap with sift-downs, pops and merges pairs with
// sift-up, then walks the tree for the codes and sums the coded bits.
// Rate is set by the single read port of each state memory.
// Reset clears the slot-map valid bits and the totals at once; no clearing pass.
// The result register lets a new request in while the last result waits; a new
// result waits in the emit state until the register is free.
module huffman_code_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcb_req_if.sink     req_i,
  hcb_res_if.source   res_o
);

  // Control state
  hcb_pkg::state_e                    state_q, state_d, ret_q;
  logic [hcb_pkg::OP_W-1:0]           op_q;
  logic [hcb_pkg::SYM_W-1:0]          sym_q, slot_q, cslot_q;
  logic [hcb_pkg::DIST_W-1:0]         dist_q;
  logic [hcb_pkg::COUNT_W-1:0]        total_q;
  logic [hcb_pkg::BITS_W-1:0]         bits_q;
  logic                               built_q;
  logic [hcb_pkg::ALPHABET_SIZE-1:0]  vld_q;

  // Build working registers
  logic [hcb_pkg::NODE_W-1:0]  i_q, hi_q, size_q, next_q, x_q, s_q, ns_q, c_q;
  logic [hcb_pkg::NODE_W-1:0]  top_q, rn_q, m_q, k_q, kr_q;
  logic [hcb_pkg::WGT_W-1:0]   wx_q, ws_q, topw_q, rw_q, wn_q;
  logic                        popn_q;
  logic [hcb_pkg::DEPTH_W-1:0] pd_q;
  logic [hcb_pkg::CODE_W-1:0]  pc_q;
  logic [hcb_pkg::PROD_W-1:0]  prod_q;
  logic [hcb_pkg::SUM_W-1:0]   sum_q;
  hcb_pkg::res_t               res_q, out_q;
  logic                        ovld_q;

  // Memories: slot map, symbol, count, node weight, children, heap order, depth/code
  logic [hcb_pkg::SYM_W-1:0]   map_mem  [hcb_pkg::ALPHABET_SIZE];
  logic [hcb_pkg::SYM_W-1:0]   sym_mem  [hcb_pkg::ALPHABET_SIZE];
  logic [hcb_pkg::COUNT_W-1:0] freq_mem [hcb_pkg::ALPHABET_SIZE];
  logic [hcb_pkg::WGT_W-1:0]   wgt_mem  [hcb_pkg::NODE_DEPTH];
  logic [2*hcb_pkg::NODE_W-1:0] kid_mem [hcb_pkg::NODE_DEPTH];
  logic [hcb_pkg::NODE_W-1:0]  heap_mem [hcb_pkg::ALPHABET_SIZE];
  logic [hcb_pkg::DEPTH_W+hcb_pkg::CODE_W-1:0] nd_mem [hcb_pkg::NODE_DEPTH];

  logic                         map_we, sym_we, freq_we, wgt_we, kid_we, heap_we, nd_we;
  logic [hcb_pkg::SYM_W-1:0]    map_ra, sym_ra, freq_ra, freq_wa, heap_ra, heap_wa;
  logic [hcb_pkg::NODE_W-1:0]   wgt_ra, wgt_wa, kid_ra, nd_ra, nd_wa;
  logic [hcb_pkg::SYM_W-1:0]    map_rd, sym_rd;
  logic [hcb_pkg::COUNT_W-1:0]  freq_rd, freq_wd;
  logic [hcb_pkg::WGT_W-1:0]    wgt_rd, wgt_wd;
  logic [2*hcb_pkg::NODE_W-1:0] kid_rd;
  logic [hcb_pkg::NODE_W-1:0]   heap_rd, heap_wd;
  logic [hcb_pkg::DEPTH_W+hcb_pkg::CODE_W-1:0] nd_rd, nd_wd;

  // Derived values
  logic                         req_fire, emit_ok;
  logic [hcb_pkg::NODE_W:0]     lidx, ridx;
  logic [hcb_pkg::NODE_W-1:0]   par_idx;
  logic [hcb_pkg::WGT_W-1:0]    wsum;
  logic [hcb_pkg::DEPTH_W-1:0]  nd_dep;
  logic [hcb_pkg::CODE_W-1:0]   nd_code;
  logic [hcb_pkg::DEPTH_W-1:0]  kid_dep;
  logic [hcb_pkg::CODE_W-1:0]   code_l, code_r;
  logic [hcb_pkg::COUNT_W-1:0]  total_inc;
  logic [hcb_pkg::BITS_W:0]     bytes_tmp;
  logic                         slot_ok;

  assign req_i.ready = (state_q == hcb_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign emit_ok     = !ovld_q || res_o.ready;

  assign lidx    = {i_q, 1'b1};
  assign ridx    = lidx + 10'd1;
  assign par_idx = 9'((m_q - 9'd1) >> 1);
  assign wsum    = topw_q + rw_q;
  assign nd_dep  = nd_rd[hcb_pkg::DEPTH_W+hcb_pkg::CODE_W-1:hcb_pkg::CODE_W];
  assign nd_code = nd_rd[hcb_pkg::CODE_W-1:0];
  assign kid_dep = nd_dep + 9'd1;
  // Codes stop growing once the parent already holds the maximum length.
  assign code_l  = (nd_dep < 9'(hcb_pkg::MAX_CODE_LEN)) ? {nd_code[62:0], 1'b0} : nd_code;
  assign code_r  = (pd_q < 9'(hcb_pkg::MAX_CODE_LEN)) ? {pc_q[62:0], 1'b1} : pc_q;
  assign total_inc = (total_q == hcb_pkg::COUNT_MAX) ? total_q : total_q + 24'd1;
  assign bytes_tmp = {1'b0, bits_q} + 33'd7;
  assign slot_ok   = built_q && ({1'b0, slot_q} < dist_q);

  // Memory arrays
  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[sym_q] <= dist_q[7:0];
    map_rd <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) sym_mem[dist_q[7:0]] <= sym_q;
    sym_rd <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk_i) begin
    if (freq_we) freq_mem[freq_wa] <= freq_wd;
    freq_rd <= freq_mem[freq_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) wgt_mem[wgt_wa] <= wgt_wd;
    wgt_rd <= wgt_mem[wgt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (kid_we) kid_mem[next_q] <= {top_q, rn_q};
    kid_rd <= kid_mem[kid_ra];
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) nd_mem[nd_wa] <= nd_wd;
    nd_rd <= nd_mem[nd_ra];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hcb_pkg::ST_IDLE: begin
        if (req_fire) begin
          unique case (hcb_pkg::op_e'(req_i.op))
            hcb_pkg::OP_COUNT: state_d = hcb_pkg::ST_CNT;
            hcb_pkg::OP_BUILD: state_d = hcb_pkg::ST_B0;
            hcb_pkg::OP_READ:  state_d = hcb_pkg::ST_RD0;
            default:           state_d = hcb_pkg::ST_IDLE;
          endcase
        end
      end
      hcb_pkg::ST_CNT:     state_d = vld_q[sym_q] ? hcb_pkg::ST_CNT_MAP : hcb_pkg::ST_IDLE;
      hcb_pkg::ST_CNT_MAP: state_d = hcb_pkg::ST_CNT_INC;
      hcb_pkg::ST_CNT_INC: state_d = hcb_pkg::ST_IDLE;
      hcb_pkg::ST_B0:      state_d = (dist_q == '0) ? hcb_pkg::ST_RPT : hcb_pkg::ST_IN_RD;
      hcb_pkg::ST_IN_RD:   state_d = hcb_pkg::ST_IN_WR;
      hcb_pkg::ST_IN_WR:   state_d = (i_q == dist_q - 9'd1) ? hcb_pkg::ST_HP0 : hcb_pkg::ST_IN_RD;
      hcb_pkg::ST_HP0:     state_d = (dist_q >= 9'd2) ? hcb_pkg::ST_HP_RD : hcb_pkg::ST_MG;
      hcb_pkg::ST_HP_RD:   state_d = hcb_pkg::ST_HP_RW;
      hcb_pkg::ST_HP_RW:   state_d = hcb_pkg::ST_HP_GO;
      hcb_pkg::ST_HP_GO:   state_d = hcb_pkg::ST_SD_L;
      hcb_pkg::ST_HP_NEXT: state_d = (hi_q == '0) ? hcb_pkg::ST_MG : hcb_pkg::ST_HP_RD;
      hcb_pkg::ST_SD_L:
        state_d = (lidx < {1'b0, size_q}) ? hcb_pkg::ST_SD_LW : hcb_pkg::ST_SD_END;
      hcb_pkg::ST_SD_LW:   state_d = hcb_pkg::ST_SD_LC;
      hcb_pkg::ST_SD_LC:
        state_d = (ridx < {1'b0, size_q}) ? hcb_pkg::ST_SD_RW : hcb_pkg::ST_SD_END;
      hcb_pkg::ST_SD_RW:   state_d = hcb_pkg::ST_SD_RC;
      hcb_pkg::ST_SD_RC:   state_d = hcb_pkg::ST_SD_END;
      hcb_pkg::ST_SD_END:  state_d = (s_q == i_q) ? ret_q : hcb_pkg::ST_SD_L;
      hcb_pkg::ST_MG:      state_d = (size_q > 9'd1) ? hcb_pkg::ST_POP0 : hcb_pkg::ST_WK0;
      hcb_pkg::ST_POP0:    state_d = hcb_pkg::ST_POP1;
      hcb_pkg::ST_POP1:    state_d = hcb_pkg::ST_POP2;
      hcb_pkg::ST_POP2:    state_d = hcb_pkg::ST_POP3;
      hcb_pkg::ST_POP3:    state_d = hcb_pkg::ST_SD_L;
      hcb_pkg::ST_POP_DONE: state_d = popn_q ? hcb_pkg::ST_MG_W : hcb_pkg::ST_POP0;
      hcb_pkg::ST_MG_W:    state_d = hcb_pkg::ST_SU_CHK;
      hcb_pkg::ST_SU_CHK:  state_d = (m_q == '0) ? hcb_pkg::ST_SU_END : hcb_pkg::ST_SU_RW;
      hcb_pkg::ST_SU_RW:   state_d = hcb_pkg::ST_SU_CMP;
      hcb_pkg::ST_SU_CMP:  state_d = (wn_q < wgt_rd) ? hcb_pkg::ST_SU_CHK : hcb_pkg::ST_SU_END;
      hcb_pkg::ST_SU_END:  state_d = hcb_pkg::ST_MG;
      hcb_pkg::ST_WK0:     state_d = hcb_pkg::ST_WK_CHK;
      hcb_pkg::ST_WK_CHK:  state_d = (k_q < dist_q) ? hcb_pkg::ST_SM_RD : hcb_pkg::ST_WK_A;
      hcb_pkg::ST_WK_A:    state_d = hcb_pkg::ST_WK_R;
      hcb_pkg::ST_WK_R:    state_d = hcb_pkg::ST_WK_CHK;
      hcb_pkg::ST_SM_RD:   state_d = (i_q == dist_q) ? hcb_pkg::ST_FIN : hcb_pkg::ST_SM_MUL;
      hcb_pkg::ST_SM_MUL:  state_d = hcb_pkg::ST_SM_ADD;
      hcb_pkg::ST_SM_ADD:  state_d = hcb_pkg::ST_SM_RD;
      hcb_pkg::ST_FIN:     state_d = hcb_pkg::ST_RPT;
      hcb_pkg::ST_RPT:     state_d = hcb_pkg::ST_EMIT;
      hcb_pkg::ST_RD0:     state_d = slot_ok ? hcb_pkg::ST_RD1 : hcb_pkg::ST_EMIT;
      hcb_pkg::ST_RD1:     state_d = hcb_pkg::ST_EMIT;
      hcb_pkg::ST_EMIT:    state_d = emit_ok ? hcb_pkg::ST_IDLE : hcb_pkg::ST_EMIT;
      default:             state_d = hcb_pkg::ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    map_we  = 1'b0;
    sym_we  = 1'b0;
    freq_we = 1'b0;
    wgt_we  = 1'b0;
    kid_we  = 1'b0;
    heap_we = 1'b0;
    nd_we   = 1'b0;
    map_ra  = sym_q;
    sym_ra  = slot_q;
    freq_ra = slot_q;
    freq_wa = cslot_q;
    freq_wd = (freq_rd == hcb_pkg::COUNT_MAX) ? freq_rd : freq_rd + 24'd1;
    wgt_ra  = heap_rd;
    wgt_wa  = next_q;
    wgt_wd  = wsum;
    kid_ra  = k_q;
    heap_ra = '0;
    heap_wa = i_q[7:0];
    heap_wd = ns_q;
    nd_ra   = k_q;
    nd_wa   = kid_rd[hcb_pkg::NODE_W-1+hcb_pkg::NODE_W:hcb_pkg::NODE_W];
    nd_wd   = {kid_dep, code_l};
    unique case (state_q)
      hcb_pkg::ST_CNT: begin
        if (!vld_q[sym_q]) begin
          // first sighting: new slot at the end of the table
          map_we  = 1'b1;
          sym_we  = 1'b1;
          freq_we = 1'b1;
          freq_wa = dist_q[7:0];
          freq_wd = 24'd1;
        end
      end
      hcb_pkg::ST_CNT_MAP: freq_ra = map_rd;
      hcb_pkg::ST_CNT_INC: freq_we = 1'b1;
      hcb_pkg::ST_IN_RD:   freq_ra = i_q[7:0];
      hcb_pkg::ST_IN_WR: begin
        wgt_we  = 1'b1;
        wgt_wa  = i_q;
        wgt_wd  = {16'd0, freq_rd};
        heap_we = 1'b1;
        heap_wd = i_q;
      end
      hcb_pkg::ST_HP_RD:   heap_ra = hi_q[7:0];
      hcb_pkg::ST_SD_L:    heap_ra = lidx[7:0];
      hcb_pkg::ST_SD_LC:   heap_ra = ridx[7:0];
      hcb_pkg::ST_SD_END: begin
        heap_we = 1'b1;
        heap_wd = (s_q == i_q) ? x_q : ns_q;
      end
      hcb_pkg::ST_POP1:    heap_ra = 8'(size_q - 9'd1);
      hcb_pkg::ST_MG_W: begin
        wgt_we = 1'b1;
        kid_we = 1'b1;
      end
      hcb_pkg::ST_SU_CHK:  heap_ra = par_idx[7:0];
      hcb_pkg::ST_SU_CMP: begin
        if (wn_q < wgt_rd) begin
          heap_we = 1'b1;
          heap_wa = m_q[7:0];
          heap_wd = c_q;
        end
      end
      hcb_pkg::ST_SU_END: begin
        heap_we = 1'b1;
        heap_wa = m_q[7:0];
        heap_wd = next_q;
      end
      hcb_pkg::ST_WK0: begin
        // root: next_q - 1 is the last merged node, or leaf 0 alone
        nd_we = 1'b1;
        nd_wa = next_q - 9'd1;
        nd_wd = '0;
      end
      hcb_pkg::ST_WK_A:    nd_we = 1'b1;
      hcb_pkg::ST_WK_R: begin
        nd_we = 1'b1;
        nd_wa = kr_q;
        nd_wd = {pd_q + 9'd1, code_r};
      end
      hcb_pkg::ST_SM_RD: begin
        nd_ra   = i_q;
        freq_ra = i_q[7:0];
      end
      hcb_pkg::ST_RD0:     nd_ra = {1'b0, slot_q};
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcb_pkg::ST_IDLE;
      dist_q  <= '0;
      total_q <= '0;
      bits_q  <= '0;
      built_q <= 1'b0;
      vld_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_o.ready) ovld_q <= 1'b0;
      unique case (state_q)
        hcb_pkg::ST_IDLE: begin
          // a byte after a build starts a new text
          if (req_fire && req_i.op == hcb_pkg::OP_COUNT && built_q) begin
            vld_q   <= '0;
            dist_q  <= '0;
            total_q <= '0;
            bits_q  <= '0;
            built_q <= 1'b0;
          end
        end
        hcb_pkg::ST_CNT: begin
          if (!vld_q[sym_q]) begin
            vld_q[sym_q] <= 1'b1;
            dist_q       <= dist_q + 9'd1;
            total_q      <= total_inc;
          end
        end
        hcb_pkg::ST_CNT_INC: total_q <= total_inc;
        hcb_pkg::ST_B0: begin
          if (dist_q == '0) begin
            bits_q  <= '0;
            built_q <= 1'b1;
          end
        end
        hcb_pkg::ST_FIN: begin
          bits_q  <= (sum_q > 41'hFFFFFFFF) ? 32'hFFFFFFFF : sum_q[31:0];
          built_q <= 1'b1;
        end
        hcb_pkg::ST_EMIT: begin
          if (emit_ok) ovld_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      hcb_pkg::ST_IDLE: begin
        if (req_fire) begin
          op_q   <= req_i.op;
          sym_q  <= req_i.symbol;
          slot_q <= req_i.slot;
        end
      end
      hcb_pkg::ST_CNT_MAP: cslot_q <= map_rd;
      hcb_pkg::ST_B0: begin
        i_q    <= '0;
        next_q <= dist_q;
        size_q <= dist_q;
      end
      hcb_pkg::ST_IN_WR:   i_q <= i_q + 9'd1;
      hcb_pkg::ST_HP0:     hi_q <= 9'((dist_q - 9'd2) >> 1);
      hcb_pkg::ST_HP_RW:   x_q <= heap_rd;
      hcb_pkg::ST_HP_GO: begin
        wx_q  <= wgt_rd;
        i_q   <= hi_q;
        ret_q <= hcb_pkg::ST_HP_NEXT;
      end
      hcb_pkg::ST_HP_NEXT: hi_q <= hi_q - 9'd1;
      hcb_pkg::ST_SD_L: begin
        s_q  <= i_q;
        ws_q <= wx_q;
      end
      hcb_pkg::ST_SD_LW, hcb_pkg::ST_SD_RW: c_q <= heap_rd;
      hcb_pkg::ST_SD_LC: begin
        if (wgt_rd < ws_q) begin
          s_q  <= lidx[8:0];
          ws_q <= wgt_rd;
          ns_q <= c_q;
        end
      end
      hcb_pkg::ST_SD_RC: begin
        if (wgt_rd < ws_q) begin
          s_q  <= ridx[8:0];
          ws_q <= wgt_rd;
          ns_q <= c_q;
        end
      end
      hcb_pkg::ST_SD_END: begin
        if (s_q != i_q) i_q <= s_q;
      end
      hcb_pkg::ST_MG:      popn_q <= 1'b0;
      hcb_pkg::ST_POP1:    top_q <= heap_rd;
      hcb_pkg::ST_POP2: begin
        topw_q <= wgt_rd;
        x_q    <= heap_rd;
        size_q <= size_q - 9'd1;
      end
      hcb_pkg::ST_POP3: begin
        wx_q  <= wgt_rd;
        i_q   <= '0;
        ret_q <= hcb_pkg::ST_POP_DONE;
      end
      hcb_pkg::ST_POP_DONE: begin
        // first pop is the right child
        if (!popn_q) begin
          rn_q   <= top_q;
          rw_q   <= topw_q;
          popn_q <= 1'b1;
        end
      end
      hcb_pkg::ST_MG_W: begin
        wn_q   <= wsum;
        m_q    <= size_q;
        size_q <= size_q + 9'd1;
      end
      hcb_pkg::ST_SU_RW:   c_q <= heap_rd;
      hcb_pkg::ST_SU_CMP: begin
        if (wn_q < wgt_rd) m_q <= par_idx;
      end
      hcb_pkg::ST_SU_END:  next_q <= next_q + 9'd1;
      hcb_pkg::ST_WK0:     k_q <= next_q - 9'd1;
      hcb_pkg::ST_WK_CHK: begin
        if (k_q < dist_q) begin
          i_q   <= '0;
          sum_q <= '0;
        end
      end
      hcb_pkg::ST_WK_A: begin
        kr_q <= kid_rd[hcb_pkg::NODE_W-1:0];
        pd_q <= nd_dep;
        pc_q <= nd_code;
      end
      hcb_pkg::ST_WK_R:    k_q <= k_q - 9'd1;
      hcb_pkg::ST_SM_MUL:  prod_q <= {24'd0, nd_dep} * {9'd0, freq_rd};
      hcb_pkg::ST_SM_ADD: begin
        sum_q <= sum_q + {8'd0, prod_q};
        i_q   <= i_q + 9'd1;
      end
      hcb_pkg::ST_RPT: begin
        res_q                <= '0;
        res_q.kind           <= hcb_pkg::KIND_TOTALS;
        res_q.char_count     <= total_q;
        res_q.distinct_count <= dist_q;
        res_q.coded_bits     <= bits_q;
        res_q.coded_bytes    <= bytes_tmp[32:3];
      end
      hcb_pkg::ST_RD0: begin
        res_q      <= '0;
        res_q.kind <= hcb_pkg::KIND_ENTRY;
      end
      hcb_pkg::ST_RD1: begin
        res_q.entry_symbol <= sym_rd;
        res_q.entry_freq   <= freq_rd;
        res_q.entry_length <= (nd_dep > 9'(hcb_pkg::MAX_CODE_LEN)) ?
                              7'(hcb_pkg::MAX_CODE_LEN) : nd_dep[6:0];
        res_q.entry_code   <= nd_code;
        res_q.entry_valid  <= 1'b1;
      end
      hcb_pkg::ST_EMIT: begin
        if (emit_ok) out_q <= res_q;
      end
      default: ;
    endcase
  end

  assign res_o.valid          = ovld_q;
  assign res_o.kind           = out_q.kind;
  assign res_o.char_count     = out_q.char_count;
  assign res_o.distinct_count = out_q.distinct_count;
  assign res_o.coded_bits     = out_q.coded_bits;
  assign res_o.coded_bytes    = out_q.coded_bytes;
  assign res_o.entry_symbol   = out_q.entry_symbol;
  assign res_o.entry_freq     = out_q.entry_freq;
  assign res_o.entry_length   = out_q.entry_length;
  assign res_o.entry_code     = out_q.entry_code;
  assign res_o.entry_valid    = out_q.entry_valid;

  // Checks
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q <= 9'(hcb_pkg::ALPHABET_SIZE))
    else $error("distinct count above alphabet size");

  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hcb_pkg::ST_MG_W |-> {1'b0, next_q} <= {dist_q, 1'b0} - 10'd2)
    else $error("merged node index beyond tree size");

  a_heap_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hcb_pkg::ST_POP0 |-> size_q > 9'd0 && size_q <= dist_q)
    else $error("pop from bad heap size");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q) == hcb_pkg::ST_EMIT)
    else $error("result raised outside emit");

endmodule
